/* rtl/core/least_loaded_core_picker_assert.svh */
// Assertion macros shared by the core picker modules.
`ifndef LEAST_LOADED_CORE_PICKER_ASSERT_SVH
`define LEAST_LOADED_CORE_PICKER_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define LLCP_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define LLCP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/core/llcp_pkg.sv */
// Types, constants and register codes of the core picker.
package llcp_pkg;

   localparam int NUM_CORES_DEFAULT = 16;
   localparam int CSR_INDEX_W       = 3;
   localparam int THRESH_W          = 48;

   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_CORE_COUNT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_CORE_COUNT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GATE_THRESHOLD    = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_THRESHOLD    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCAL_THRESHOLD   = 3'd4;

   localparam logic [4:0]          SMALL_CORE_COUNT_RST  = 5'd4;
   localparam logic [4:0]          ACTIVE_CORE_COUNT_RST = 5'd16;
   localparam logic [THRESH_W-1:0] GATE_THRESHOLD_RST    = 48'd0;
   localparam logic [THRESH_W-1:0] LONG_THRESHOLD_RST    = 48'd120000000;
   localparam logic [THRESH_W-1:0] LOCAL_THRESHOLD_RST   = 48'd2400000;

   localparam logic [THRESH_W-1:0] JOB_UNKNOWN = '1;
   localparam logic                OP_ASSIGN   = 1'b0;
   localparam logic                OP_IDLE     = 1'b1;

   typedef struct packed {
      logic [4:0]          small_core_count;
      logic [4:0]          active_core_count;
      logic [THRESH_W-1:0] gate_threshold;
      logic [THRESH_W-1:0] long_threshold;
      logic [THRESH_W-1:0] local_threshold;
   } cfg_type;

   typedef struct packed {
      logic        opcode;
      logic [47:0] job_time;
      logic [63:0] now_time;
      logic [3:0]  local_core;
   } req_type;

   typedef struct packed {
      logic [3:0]  chosen_core;
      logic [63:0] finish_time;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic scan_init;
      logic scan_rd;
      logic small_init;
      logic clamp;
      logic fetch;
      logic base;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic direct;
      logic short_known;
      logic has_small;
      logic last_big;
      logic last_small;
   } ctrl_status_type;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_DECIDE    = 9'b000000010,
      ST_BIG       = 9'b000000100,
      ST_DRAIN_BIG = 9'b000001000,
      ST_SMALL     = 9'b000010000,
      ST_DRAIN     = 9'b000100000,
      ST_FETCH     = 9'b001000000,
      ST_BASE      = 9'b010000000,
      ST_COMMIT    = 9'b100000000
   } state_type;

endpackage

/* rtl/core/least_loaded_core_picker.sv */
// Top level of the earliest-finish-time core picker.
// Use: write thresholds and core counts on the csr_ channel while no transaction is in
// flight; csr_ready is always high. Each req_ transaction either assigns a job
// (opcode 0) or marks local_core idle (opcode 1) and yields exactly one rsp_
// transaction with the chosen core and its new busy-until timestamp.
// Timing: one transaction at a time; req_ready is high only while the sequencer
// is idle. An idle event, a job that stays local, or a configuration without big
// cores goes straight to the chosen core. A job that searches the big cores also
// considers the small cores when short enough. The timestamp RAM has one read
// port: the search reads one core per cycle, then rereads the chosen core for the
// saturating update.
// Reset: timestamps read as zero (per-core valid bits are cleared), registers take
// their default values, and no result is pending.
// Stall: a finished result waits in the output register; the next request can be
// taken and searched meanwhile, and its result is held back until the register frees.
module least_loaded_core_picker import llcp_pkg::*; #(
   parameter int NUM_CORES = NUM_CORES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THRESH_W-1:0]    csr_data
);

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   llcp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   llcp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   llcp_datapath #(
      .NUM_CORES (NUM_CORES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/core/llcp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module llcp_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/llcp_csr.sv */
// Configuration registers of the core picker.
module llcp_csr import llcp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [THRESH_W-1:0]    csr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_SMALL_CORE_COUNT:  cfg_in.small_core_count  = csr_data[4:0];
            CSR_ACTIVE_CORE_COUNT: cfg_in.active_core_count = csr_data[4:0];
            CSR_GATE_THRESHOLD:    cfg_in.gate_threshold    = csr_data;
            CSR_LONG_THRESHOLD:    cfg_in.long_threshold    = csr_data;
            CSR_LOCAL_THRESHOLD:   cfg_in.local_threshold   = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.small_core_count  <= SMALL_CORE_COUNT_RST;
         cfg_ff.active_core_count <= ACTIVE_CORE_COUNT_RST;
         cfg_ff.gate_threshold    <= GATE_THRESHOLD_RST;
         cfg_ff.long_threshold    <= LONG_THRESHOLD_RST;
         cfg_ff.local_threshold   <= LOCAL_THRESHOLD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

/* rtl/core/llcp_ctrl.sv */
// Sequencer of the core picker: scan, fetch, update and result handoff.
`include "least_loaded_core_picker_assert.svh"

module llcp_ctrl import llcp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            cmd.scan_init = 1'b1;
            state_in      = status.direct ? ST_FETCH : ST_BIG;
         end
         ST_BIG: begin
            cmd.scan_rd = 1'b1;
            if (status.last_big) begin
               state_in = (status.short_known && status.has_small) ? ST_DRAIN_BIG
                                                                   : ST_DRAIN;
            end
         end
         ST_DRAIN_BIG: begin
            cmd.small_init = 1'b1;
            state_in       = ST_SMALL;
         end
         ST_SMALL: begin
            cmd.scan_rd = 1'b1;
            cmd.clamp   = 1'b1;
            if (status.last_small) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FETCH;
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_BASE;
         end
         ST_BASE: begin
            cmd.base = 1'b1;
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `LLCP_ASSERT_SAME(a_commit_slot_free, cmd.commit, slot_free, "result overwritten")
   `LLCP_ASSERT_NEXT(a_commit_shows_result, cmd.commit, rsp_valid_ff, "result not presented")

endmodule

/* rtl/core/llcp_datapath.sv */
// Datapath of the core picker: timestamp store, minimum search and saturating update.
`include "least_loaded_core_picker_assert.svh"

module llcp_datapath import llcp_pkg::*; #(
   parameter int NUM_CORES = NUM_CORES_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  req_type         req_data,
   input  ctrl_cmd_type    cmd,
   output ctrl_status_type status,
   output rsp_type         rsp_data
);

   localparam int         AW      = $clog2(NUM_CORES);
   localparam logic [7:0] CORES_W = 8'(NUM_CORES);

   function automatic logic [AW-1:0] core_mod(input logic [3:0] v);
      logic [6:0] r;
      r = 7'(v);
      for (int k = 0; k < 8; k++) begin
         if (r >= 7'(NUM_CORES)) begin
            r = r - 7'(NUM_CORES);
         end
      end
      return AW'(r);
   endfunction

   logic                 op_ff;
   logic [47:0]          job_ff;
   logic [63:0]          now_ff;
   logic [AW-1:0]        local_ff;
   logic [AW-1:0]        scan_idx_ff;
   logic [AW-1:0]        scan_idx_in;
   logic [63:0]          best_ff;
   logic [63:0]          best_in;
   logic [AW-1:0]        pick_ff;
   logic [AW-1:0]        pick_in;
   logic                 cmp_valid_ff;
   logic [AW-1:0]        rd_idx_ff;
   logic [AW-1:0]        target_ff;
   logic [63:0]          base_ff;
   rsp_type              rsp_ff;
   logic [NUM_CORES-1:0] valid_ff;

   logic [7:0]    active_w;
   logic [7:0]    small_w;
   logic [7:0]    scan_next;
   logic          nobig;
   logic          gate_hit;
   logic          force_local;
   logic          direct;
   logic [63:0]   ram_rd;
   logic [63:0]   rd_eff;
   logic [AW-1:0] fetch_idx;
   logic [AW-1:0] rd_addr;
   logic          rd_en;
   logic [63:0]   addend;
   logic [64:0]   sum;
   logic [63:0]   finish;
   logic          wr_en;

   assign active_w    = (8'(cfg.active_core_count) > CORES_W) ? CORES_W
                                                              : 8'(cfg.active_core_count);
   assign small_w     = 8'(cfg.small_core_count);
   assign nobig       = (active_w <= small_w);
   assign gate_hit    = (job_ff < cfg.gate_threshold);
   assign force_local = (job_ff < cfg.local_threshold);
   assign direct      = op_ff || nobig || gate_hit || force_local;
   assign scan_next   = 8'(scan_idx_ff) + 8'd1;

   assign status.direct      = direct;
   assign status.short_known = (job_ff < cfg.long_threshold) && (job_ff != JOB_UNKNOWN);
   assign status.has_small   = (small_w != 8'd0);
   assign status.last_big    = (scan_next >= active_w);
   assign status.last_small  = (scan_next >= small_w);

   assign rd_eff    = valid_ff[rd_idx_ff] ? ram_rd : '0;
   assign fetch_idx = direct ? local_ff : pick_ff;
   assign rd_addr   = cmd.fetch ? fetch_idx : scan_idx_ff;
   assign rd_en     = cmd.scan_rd || cmd.fetch;

   always_comb begin
      if (op_ff || nobig) begin
         addend = '0;
      end else if (gate_hit) begin
         addend = 64'(job_ff);
      end else if (job_ff == '0) begin
         addend = 64'd1;
      end else begin
         addend = 64'(job_ff);
      end
   end

   assign sum    = {1'b0, base_ff} + {1'b0, addend};
   assign finish = sum[64] ? '1 : sum[63:0];
   assign wr_en  = cmd.commit && (op_ff || !nobig);

   always_comb begin
      scan_idx_in = scan_idx_ff;
      if (cmd.scan_init) begin
         scan_idx_in = AW'(cfg.small_core_count);
      end else if (cmd.small_init) begin
         scan_idx_in = '0;
      end else if (cmd.scan_rd) begin
         scan_idx_in = scan_idx_ff + AW'(1);
      end
   end

   always_comb begin
      best_in = best_ff;
      pick_in = pick_ff;
      if (cmd.scan_init) begin
         best_in = '1;
         pick_in = AW'(cfg.small_core_count);
      end else if (cmp_valid_ff) begin
         if (rd_eff < best_ff) begin
            best_in = rd_eff;
            pick_in = rd_idx_ff;
         end
      end else if (cmd.clamp && (best_ff < now_ff)) begin
         best_in = now_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         cmp_valid_ff <= 1'b0;
      end else begin
         cmp_valid_ff <= cmd.scan_rd;
         if (wr_en) begin
            valid_ff[target_ff] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_data.opcode;
         job_ff   <= req_data.job_time;
         now_ff   <= req_data.now_time;
         local_ff <= core_mod(req_data.local_core);
      end
      scan_idx_ff <= scan_idx_in;
      best_ff     <= best_in;
      pick_ff     <= pick_in;
      if (rd_en) begin
         rd_idx_ff <= rd_addr;
      end
      if (cmd.fetch) begin
         target_ff <= fetch_idx;
      end
      if (cmd.base) begin
         if (op_ff) begin
            base_ff <= now_ff;
         end else if (nobig) begin
            base_ff <= rd_eff;
         end else begin
            base_ff <= (rd_eff > now_ff) ? rd_eff : now_ff;
         end
      end
      if (cmd.commit) begin
         rsp_ff.chosen_core <= 4'(target_ff);
         rsp_ff.finish_time <= finish;
      end
   end

   llcp_ram #(
      .WIDTH (64),
      .DEPTH (NUM_CORES)
   ) u_busy_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (target_ff),
      .wr_data (finish),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign rsp_data = rsp_ff;

   `LLCP_ASSERT_SAME(a_scan_in_range, cmd.scan_rd, 8'(scan_idx_ff) < active_w, "scan past active cores")
   `LLCP_ASSERT_SAME(a_pick_in_range, cmd.fetch && !direct, 8'(pick_ff) < active_w, "pick outside active cores")

endmodule
